FILE: hw/rtl/apm_pkg.sv
`default_nettype none

package apm_pkg;

  // Field widths of the request and result items.
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SEL_W    = 5;
  localparam int unsigned THRESH_W = 25;

  // Request transfer: now_ns and bucket_index in tdata, req_type in tuser.
  localparam int unsigned IN_FIELDS_W = TIME_W + SEL_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned IN_TUSER_W  = 2;

  // Result transfer: all result fields packed in tdata.
  localparam int unsigned OUT_FIELDS_W = 1 + 5 * TIME_W + 2 * COUNT_W + THRESH_W + TIME_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Histogram size, default and largest supported value.
  localparam int unsigned NUM_BUCKETS_DEF = 20;
  localparam int unsigned NUM_BUCKETS_MAX = 32;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_ACTIVE = 2'd1,
    OP_IDLE   = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic              measure;
    logic [TIME_W-1:0] period;
    logic              is_active;
    logic [TIME_W-1:0] generation;
    logic [TIME_W-1:0] active_stamp;
    logic [TIME_W-1:0] idle_stamp;
    logic [SEL_W-1:0]  bucket_index;
  } cmd_t;

  // Survival bucket thresholds in ns; indexes past the twentieth use the largest.
  function automatic logic [THRESH_W-1:0] bucket_threshold(input logic [SEL_W-1:0] idx);
    logic [THRESH_W-1:0] thr;
    case (idx)
      5'd0:    thr = 25'd20000;
      5'd1:    thr = 25'd50000;
      5'd2:    thr = 25'd75000;
      5'd3:    thr = 25'd100000;
      5'd4:    thr = 25'd125000;
      5'd5:    thr = 25'd141000;
      5'd6:    thr = 25'd161000;
      5'd7:    thr = 25'd180000;
      5'd8:    thr = 25'd200000;
      5'd9:    thr = 25'd250000;
      5'd10:   thr = 25'd300000;
      5'd11:   thr = 25'd400000;
      5'd12:   thr = 25'd500000;
      5'd13:   thr = 25'd750000;
      5'd14:   thr = 25'd1000000;
      5'd15:   thr = 25'd1500000;
      5'd16:   thr = 25'd2500000;
      5'd17:   thr = 25'd5000000;
      5'd18:   thr = 25'd10000000;
      default: thr = 25'd20000000;
    endcase
    return thr;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/activity_period_monitor.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata: now_ns, bucket_index; tuser: req_type
// m_*       out  m_tvalid/m_tready  tdata: the ten result fields, one result per request
//
// One request is taken every cycle while the command queue has room; each
// result passes through the command queue into the result register (the
// accepting edge writes the command queue, and the result register loads
// from the queue head once the back can take the command).
// rst is synchronous and clears all statistics, stamps and the generation.
// A stalled result holds the back; the two-entry command queue then fills
// and s_tready falls until the result transfer completes.

module activity_period_monitor #(
  parameter int unsigned NUM_BUCKETS = apm_pkg::NUM_BUCKETS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // tdata fields from bit 0: now_ns[63:0], bucket_index[68:64], zero fill.
  input  wire  [apm_pkg::IN_TDATA_W-1:0]  s_tdata,
  // tuser fields from bit 0: req_type[1:0].
  input  wire  [apm_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // tdata fields from bit 0: is_active[0], generation_count[64:1],
  // idle_average_ns[128:65], active_average_ns[192:129],
  // idle_samples_total[224:193], active_samples_total[256:225],
  // last_active_time_ns[320:257], last_idle_time_ns[384:321],
  // bucket_threshold_ns[409:385], survival_count[473:410], zero fill.
  output logic [apm_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import apm_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  // Front: takes requests, keeps stamps and generation, classifies.
  apm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Command queue between the two sides.
  apm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_cmd    (push_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  // Back: averages, sample counts, histogram and result register.
  apm_back #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // A full queue always has a command waiting at its head.
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_valid)
    else $error("request side stalled with an empty command queue");

  // The back only pops when the result register can take the result.
  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> (!m_tvalid || m_tready))
    else $error("command popped while the result register was stalled");

  // A transfer into an empty queue shows up at its head in the next cycle.
  a_push_reaches_head: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !q_valid) |=> q_valid)
    else $error("accepted request did not reach the queue head");

  // Coming out of reset the block is ready for requests.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (s_tready && !m_tvalid))
    else $error("block not empty and ready after reset");

endmodule

`default_nettype wire

FILE: hw/rtl/apm_front.sv
`default_nettype none

module apm_front (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // tdata fields from bit 0: now_ns[63:0], bucket_index[68:64], zero fill.
  input  wire  [apm_pkg::IN_TDATA_W-1:0]   s_tdata,
  // tuser fields from bit 0: req_type[1:0].
  input  wire  [apm_pkg::IN_TUSER_W-1:0]   s_tuser,
  output logic                             push_valid,
  input  wire                              push_ready,
  output apm_pkg::cmd_t                    push_cmd
);
  import apm_pkg::*;

  logic              active_flag;
  logic              active_flag_next;
  logic [TIME_W-1:0] generation;
  logic [TIME_W-1:0] generation_next;
  logic [TIME_W-1:0] active_stamp;
  logic [TIME_W-1:0] active_stamp_next;
  logic [TIME_W-1:0] idle_stamp;
  logic [TIME_W-1:0] idle_stamp_next;

  logic [TIME_W-1:0] now;
  logic [SEL_W-1:0]  sel;
  op_t               op;
  logic [TIME_W-1:0] stamp;
  logic              take;

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid;
  assign take       = s_tvalid && push_ready;

  // Decode the request and work out the period and the new stamps.
  always_comb begin
    now   = s_tdata[TIME_W-1:0];
    sel   = s_tdata[TIME_W+SEL_W-1:TIME_W];
    op    = op_t'(s_tuser);
    stamp = (op == OP_IDLE) ? active_stamp : idle_stamp;

    active_flag_next  = active_flag;
    generation_next   = generation;
    active_stamp_next = active_stamp;
    idle_stamp_next   = idle_stamp;

    case (op)
      OP_START: begin
        active_flag_next  = 1'b0;
        active_stamp_next = '0;
        idle_stamp_next   = now;
        generation_next   = generation + 1'b1;
      end
      OP_ACTIVE: begin
        active_flag_next  = 1'b1;
        active_stamp_next = now;
        generation_next   = generation + 1'b1;
      end
      OP_IDLE: begin
        active_flag_next = 1'b0;
        idle_stamp_next  = now;
      end
      default: begin
      end
    endcase

    push_cmd.op           = op;
    push_cmd.measure      = ((op == OP_ACTIVE) || (op == OP_IDLE)) &&
                            (stamp != '0) && (now > stamp);
    push_cmd.period       = now - stamp;
    push_cmd.is_active    = active_flag_next;
    push_cmd.generation   = generation_next;
    push_cmd.active_stamp = active_stamp_next;
    push_cmd.idle_stamp   = idle_stamp_next;
    push_cmd.bucket_index = sel;
  end

  // Stamp, flag and generation state advance with each request transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag  <= 1'b0;
      generation   <= '0;
      active_stamp <= '0;
      idle_stamp   <= '0;
    end else if (take) begin
      active_flag  <= active_flag_next;
      generation   <= generation_next;
      active_stamp <= active_stamp_next;
      idle_stamp   <= idle_stamp_next;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/apm_queue.sv
`default_nettype none

module apm_queue (
  input  wire           clk,
  input  wire           rst,
  input  wire           in_valid,
  output logic          in_ready,
  input  apm_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  wire           out_ready,
  output apm_pkg::cmd_t out_cmd
);
  import apm_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t              entries [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = (count != CntW'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  // Pointers wrap around the power-of-two depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/apm_back.sv
`default_nettype none

module apm_back #(
  parameter int unsigned NUM_BUCKETS = apm_pkg::NUM_BUCKETS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cmd_valid,
  output logic                            cmd_ready,
  input  apm_pkg::cmd_t                   cmd,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // tdata fields from bit 0: is_active[0], generation_count[64:1],
  // idle_average_ns[128:65], active_average_ns[192:129],
  // idle_samples_total[224:193], active_samples_total[256:225],
  // last_active_time_ns[320:257], last_idle_time_ns[384:321],
  // bucket_threshold_ns[409:385], survival_count[473:410], zero fill.
  output logic [apm_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import apm_pkg::*;

  localparam int unsigned IdxW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

  logic [TIME_W-1:0]  idle_average;
  logic [TIME_W-1:0]  idle_average_next;
  logic [TIME_W-1:0]  active_average;
  logic [TIME_W-1:0]  active_average_next;
  logic [COUNT_W-1:0] idle_count;
  logic [COUNT_W-1:0] idle_count_next;
  logic [COUNT_W-1:0] active_count;
  logic [COUNT_W-1:0] active_count_next;
  logic [TIME_W-1:0]  survival [NUM_BUCKETS];
  logic [TIME_W-1:0]  survival_next [NUM_BUCKETS];

  logic               take;
  logic [TIME_W-1:0]  avg_old;
  logic [TIME_W-1:0]  avg_new;
  logic [TIME_W-1:0]  diff;
  logic               rising;
  logic               sel_ok;
  logic [THRESH_W-1:0] thr_sel;
  logic [TIME_W-1:0]  surv_sel;
  logic [OUT_FIELDS_W-1:0] result;

  assign cmd_ready = !m_tvalid || m_tready;
  assign take      = cmd_valid && cmd_ready;

  // Shared moving-average unit: one eighth of the gap toward the sample.
  always_comb begin
    avg_old = (cmd.op == OP_ACTIVE) ? idle_average : active_average;
    rising  = (cmd.period >= avg_old);
    diff    = rising ? (cmd.period - avg_old) : (avg_old - cmd.period);
    if (avg_old == '0) begin
      avg_new = cmd.period;
    end else if (rising) begin
      avg_new = avg_old + (diff >> 3);
    end else begin
      avg_new = avg_old - (diff >> 3);
    end
  end

  // Statistics update for the command at the queue head.
  always_comb begin
    idle_average_next   = idle_average;
    active_average_next = active_average;
    idle_count_next     = idle_count;
    active_count_next   = active_count;
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      survival_next[i] = survival[i];
    end

    case (cmd.op)
      OP_START: begin
        idle_average_next   = '0;
        active_average_next = '0;
        idle_count_next     = '0;
        active_count_next   = '0;
        for (int i = 0; i < NUM_BUCKETS; i++) begin
          survival_next[i] = '0;
        end
      end
      OP_ACTIVE: begin
        if (cmd.measure) begin
          idle_average_next = avg_new;
          idle_count_next   = idle_count + 1'b1;
          for (int i = 0; i < NUM_BUCKETS; i++) begin
            if (cmd.period > TIME_W'(bucket_threshold(SEL_W'(i)))) begin
              survival_next[i] = survival[i] + 1'b1;
            end
          end
        end
      end
      OP_IDLE: begin
        if (cmd.measure) begin
          active_average_next = avg_new;
          active_count_next   = active_count + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Selected bucket report, zero past the last bucket.
  always_comb begin
    sel_ok = ({1'b0, cmd.bucket_index} < (SEL_W + 1)'(NUM_BUCKETS));
    if (sel_ok) begin
      thr_sel  = bucket_threshold(cmd.bucket_index);
      surv_sel = survival_next[cmd.bucket_index[IdxW-1:0]];
    end else begin
      thr_sel  = '0;
      surv_sel = '0;
    end
    result = {surv_sel, thr_sel, cmd.idle_stamp, cmd.active_stamp,
              active_count_next, idle_count_next, active_average_next,
              idle_average_next, cmd.generation, cmd.is_active};
  end

  // Statistics registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_average   <= '0;
      active_average <= '0;
      idle_count     <= '0;
      active_count   <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        survival[i] <= '0;
      end
    end else if (take) begin
      idle_average   <= idle_average_next;
      active_average <= active_average_next;
      idle_count     <= idle_count_next;
      active_count   <= active_count_next;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        survival[i] <= survival_next[i];
      end
    end
  end

  // Result register; it holds while the result transfer is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd_ready) begin
      m_tvalid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= OUT_TDATA_W'(result);
    end
  end

endmodule

`default_nettype wire

FILE: test/activity_period_monitor_test.sv
`default_nettype none

module activity_period_monitor_test;
  import apm_pkg::*;

  localparam int unsigned BUCKETS       = NUM_BUCKETS_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned LONG_HOLD     = 150;

  // One request as the sender offers it.
  typedef struct {
    op_t               op;
    logic [TIME_W-1:0] now;
    logic [SEL_W-1:0]  sel;
    bit                drain_first;
  } request_t;

  // One status report as the block should return it.
  typedef struct {
    logic                is_active;
    logic [TIME_W-1:0]   generation;
    logic [TIME_W-1:0]   idle_avg;
    logic [TIME_W-1:0]   active_avg;
    logic [COUNT_W-1:0]  idle_total;
    logic [COUNT_W-1:0]  active_total;
    logic [TIME_W-1:0]   active_mark;
    logic [TIME_W-1:0]   idle_mark;
    logic [THRESH_W-1:0] threshold;
    logic [TIME_W-1:0]   survival;
  } status_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  wire                    s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  wire                    m_tvalid;
  logic                   m_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] m_tdata;

  activity_period_monitor #(
    .NUM_BUCKETS(BUCKETS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // Survival thresholds in ns for the first twenty buckets.
  logic [THRESH_W-1:0] survival_limit_ns [20] = '{
    25'd20000,   25'd50000,   25'd75000,   25'd100000,  25'd125000,
    25'd141000,  25'd161000,  25'd180000,  25'd200000,  25'd250000,
    25'd300000,  25'd400000,  25'd500000,  25'd750000,  25'd1000000,
    25'd1500000, 25'd2500000, 25'd5000000, 25'd10000000, 25'd20000000
  };

  // Predicted state of the monitored client.
  logic               model_active;
  logic [TIME_W-1:0]  model_generation;
  logic [TIME_W-1:0]  stamp_active;
  logic [TIME_W-1:0]  stamp_idle;
  logic [TIME_W-1:0]  avg_idle;
  logic [TIME_W-1:0]  avg_active;
  logic [COUNT_W-1:0] count_idle;
  logic [COUNT_W-1:0] count_active;
  logic [TIME_W-1:0]  survival_tally [BUCKETS];

  request_t request_q [$];
  status_t  expected_status_q [$];

  int error_count     = 0;
  int total_requests  = 0;
  int accepted_count  = 0;
  int results_seen    = 0;
  int idle_measured   = 0;
  int long_holds      = 0;
  int drain_pauses    = 0;
  int op_seen [4]     = '{0, 0, 0, 0};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #3000000;
    $display("Timeout with %0d results still outstanding.", expected_status_q.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [THRESH_W-1:0] limit_ns(int idx);
    return (idx < 20) ? survival_limit_ns[idx] : 25'd20000000;
  endfunction

  // Moving average with weight 1/8, seeded by the first sample.
  function automatic logic [TIME_W-1:0] smooth_average(logic [TIME_W-1:0] avg,
                                                       logic [TIME_W-1:0] sample);
    if (avg == 0) return sample;
    if (sample >= avg) return avg + ((sample - avg) >> 3);
    return avg - ((avg - sample) >> 3);
  endfunction

  // Advance the predicted state by one request and report the state after it.
  function automatic status_t apply_request(request_t req);
    status_t           st;
    logic [TIME_W-1:0] period;
    case (req.op)
      OP_START: begin
        model_active = 1'b0;
        stamp_active = '0;
        avg_idle     = '0;
        avg_active   = '0;
        count_idle   = '0;
        count_active = '0;
        for (int i = 0; i < BUCKETS; i++) survival_tally[i] = '0;
        stamp_idle       = req.now;
        model_generation = model_generation + 1;
      end
      OP_ACTIVE: begin
        if (stamp_idle != 0 && req.now > stamp_idle) begin
          period   = req.now - stamp_idle;
          avg_idle = smooth_average(avg_idle, period);
          for (int i = 0; i < BUCKETS; i++) begin
            if (period > limit_ns(i)) survival_tally[i] = survival_tally[i] + 1;
          end
          count_idle    = count_idle + 1;
          idle_measured = idle_measured + 1;
        end
        stamp_active     = req.now;
        model_generation = model_generation + 1;
        model_active     = 1'b1;
      end
      OP_IDLE: begin
        if (stamp_active != 0 && req.now > stamp_active) begin
          avg_active   = smooth_average(avg_active, req.now - stamp_active);
          count_active = count_active + 1;
        end
        stamp_idle   = req.now;
        model_active = 1'b0;
      end
      default: ;
    endcase
    st.is_active    = model_active;
    st.generation   = model_generation;
    st.idle_avg     = avg_idle;
    st.active_avg   = avg_active;
    st.idle_total   = count_idle;
    st.active_total = count_active;
    st.active_mark  = stamp_active;
    st.idle_mark    = stamp_idle;
    if (req.sel < BUCKETS) begin
      st.threshold = limit_ns(req.sel);
      st.survival  = survival_tally[req.sel];
    end else begin
      st.threshold = '0;
      st.survival  = '0;
    end
    return st;
  endfunction

  task automatic queue_request(op_t op, logic [TIME_W-1:0] now, logic [SEL_W-1:0] sel,
                               bit drain_first);
    request_t req;
    req.op          = op;
    req.now         = now;
    req.sel         = sel;
    req.drain_first = drain_first;
    request_q.push_back(req);
  endtask

  function automatic logic [SEL_W-1:0] pick_bucket();
    if ($urandom_range(0, 9) < 8) return SEL_W'($urandom_range(0, BUCKETS - 1));
    return SEL_W'($urandom_range(BUCKETS, 31));
  endfunction

  // Period lengths, some of them clustered around the bucket thresholds.
  function automatic logic [TIME_W-1:0] pick_period();
    logic [TIME_W-1:0] base;
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(1, 30000);
      2, 3, 4: begin
        base = limit_ns($urandom_range(0, 19));
        return base + $urandom_range(0, 2) - 1;
      end
      5, 6:    return $urandom_range(30000, 3000000);
      7:       return $urandom_range(3000000, 30000000);
      8:       return '0;
      default: return {$urandom_range(0, 15), $urandom};
    endcase
  endfunction

  // Sessions opened by a start, then alternating marks with random periods.
  task automatic add_random_traffic(int target);
    logic [TIME_W-1:0] stamp;
    op_t               last_op;
    op_t               op;
    int                n;
    int                k;
    stamp = 64'd1000;
    n     = 0;
    while (n < target) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 3) == 0) stamp = {$urandom, $urandom};
        else stamp = $urandom_range(1, 1000000);
      end
      if ($urandom_range(0, 9) != 0) begin
        queue_request(OP_START, stamp, pick_bucket(), 1'b0);
        n++;
      end
      last_op = OP_IDLE;
      repeat ($urandom_range(4, 40)) begin
        k = $urandom_range(0, 99);
        if (k < 8) op = OP_READ;
        else if (k < 13) op = last_op;
        else op = (last_op == OP_ACTIVE) ? OP_IDLE : OP_ACTIVE;
        if (op != OP_READ) begin
          k = $urandom_range(0, 99);
          if (k < 5) stamp = stamp - $urandom_range(0, 50000);
          else if (k < 8) stamp = {$urandom, $urandom};
          else stamp = stamp + pick_period();
          last_op = op;
        end
        queue_request(op, stamp, pick_bucket(), (n % 300) == 299);
        n++;
      end
    end
  endtask

  // Directed opening: missing stamps, time standing or running back, exact
  // thresholds, out-of-range buckets and the extremes of the timestamp.
  task automatic add_directed_traffic();
    logic [TIME_W-1:0] t;
    queue_request(OP_READ,   64'd0,    5'd0,  1'b0);
    queue_request(OP_ACTIVE, 64'd5000, 5'd1,  1'b0);
    queue_request(OP_IDLE,   64'd5000, 5'd2,  1'b0);
    queue_request(OP_ACTIVE, 64'd4000, 5'd3,  1'b0);
    queue_request(OP_IDLE,   64'd0,    5'd4,  1'b0);
    queue_request(OP_ACTIVE, 64'd100,  5'd5,  1'b0);
    t = 64'd1000000;
    queue_request(OP_START,  t, 5'd31, 1'b0);
    t = t + 64'd20000;
    queue_request(OP_ACTIVE, t, 5'd0,  1'b0);
    t = t + 64'd300;
    queue_request(OP_IDLE,   t, 5'd19, 1'b0);
    t = t + 64'd20001;
    queue_request(OP_ACTIVE, t, 5'd0,  1'b0);
    t = t + 64'd7000;
    queue_request(OP_IDLE,   t, 5'd1,  1'b0);
    t = t + 64'd25000000;
    queue_request(OP_ACTIVE, t, 5'd19, 1'b0);
    t = t + 64'd90000000;
    queue_request(OP_IDLE,   t, 5'd10, 1'b0);
    t = t + 64'd20000000;
    queue_request(OP_ACTIVE, t, 5'd19, 1'b0);
    queue_request(OP_READ,   t, 5'd20, 1'b0);
    queue_request(OP_READ,   t, 5'd31, 1'b0);
    queue_request(OP_START,  64'hFFFF_FFFF_FFFF_FFF0, 5'd18, 1'b0);
    queue_request(OP_IDLE,   64'hFFFF_FFFF_FFFF_FFFF, 5'd17, 1'b0);
    queue_request(OP_ACTIVE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 1'b0);
    queue_request(OP_START,  64'd1, 5'd15, 1'b0);
    queue_request(OP_ACTIVE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd18, 1'b0);
    queue_request(OP_IDLE,   64'hFFFF_FFFF_FFFF_FFFF, 5'd0,  1'b0);
    queue_request(OP_START,  64'h8000_0000_0000_0000, 5'd19, 1'b0);
    queue_request(OP_READ,   64'h5555_AAAA_5555_AAAA, 5'd21, 1'b1);
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // Request driver: bursts of transfers separated by random gaps.
  always @(posedge clk) begin : request_driver
    static request_t offered;
    static int       burst_left = 1;
    static int       gap_left = 0;
    logic [IN_TDATA_W-1:0] word;
    bit                    load;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_status_q.push_back(apply_request(offered));
        op_seen[offered.op]++;
        accepted_count++;
      end
      if (!s_tvalid || s_tready) begin
        load = 1'b0;
        word = '0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          if (request_q[0].drain_first && expected_status_q.size() != 0) begin
            // Hold the next request until every pending result is back.
          end else begin
            if (request_q[0].drain_first) drain_pauses++;
            offered = request_q.pop_front();
            load = 1'b1;
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 40);
              gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            end else begin
              burst_left--;
            end
          end
        end
        s_tvalid <= load;
        if (load) begin
          word[TIME_W-1:0]       = offered.now;
          word[TIME_W +: SEL_W]  = offered.sel;
          s_tdata <= word;
          s_tuser <= offered.op;
        end
      end
    end
  end

  // Result monitor: checks each transfer and drives its own stall pattern.
  always @(posedge clk) begin : result_monitor
    static int cycle_count = 0;
    static int hold_left = 0;
    static int next_hold_at = 200;
    status_t   want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_status_q.size() == 0) begin
          $error("result transfer with no request outstanding");
          error_count++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("is_active",            want.is_active,    m_tdata[0]);
          check_field("generation_count",     want.generation,   m_tdata[64:1]);
          check_field("idle_average_ns",      want.idle_avg,     m_tdata[128:65]);
          check_field("active_average_ns",    want.active_avg,   m_tdata[192:129]);
          check_field("idle_samples_total",   want.idle_total,   m_tdata[224:193]);
          check_field("active_samples_total", want.active_total, m_tdata[256:225]);
          check_field("last_active_time_ns",  want.active_mark,  m_tdata[320:257]);
          check_field("last_idle_time_ns",    want.idle_mark,    m_tdata[384:321]);
          check_field("bucket_threshold_ns",  want.threshold,    m_tdata[409:385]);
          check_field("survival_count",       want.survival,     m_tdata[473:410]);
        end
      end
      cycle_count++;
      // A long hold-off now and then lets the request side back up.
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at = next_hold_at + 600;
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case ((cycle_count / 97) % 4)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) != 0);
          default: m_tready <= ((cycle_count % 7) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    model_active     = 1'b0;
    model_generation = '0;
    stamp_active     = '0;
    stamp_idle       = '0;
    avg_idle         = '0;
    avg_active       = '0;
    count_idle       = '0;
    count_active     = '0;
    for (int i = 0; i < BUCKETS; i++) survival_tally[i] = '0;
    add_directed_traffic();
    add_random_traffic(RANDOM_ITEMS);
    total_requests = request_q.size();
    while (accepted_count < total_requests) @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d requests: %0d start, %0d active, %0d idle, %0d read.",
             results_seen, accepted_count, op_seen[OP_START], op_seen[OP_ACTIVE],
             op_seen[OP_IDLE], op_seen[OP_READ]);
    $display("Idle periods measured: %0d; long result stalls: %0d; drain pauses: %0d.",
             idle_measured, long_holds, drain_pauses);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/apm_pkg.sv
hw/rtl/apm_front.sv
hw/rtl/apm_queue.sv
hw/rtl/apm_back.sv
hw/rtl/activity_period_monitor.sv
test/activity_period_monitor_test.sv
